// ===== hw/rtl/h2r_pkg.sv =====
// shared types, constants and fixed-point helpers of the hsb to rgb converter
package h2r_pkg;

    // fixed-point format: 1.0 is 2^FRAC_BITS
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] FX_ONE  = 17'h10000;
    localparam logic [16:0] FX_HALF = 17'h08000;

    // hue sectors, one per sixth of a turn
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } t_hsb;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // after input scaling
    typedef struct packed {
        t_sector     sector;
        logic        sat_zero;
        logic [15:0] frac;
        logic [16:0] sat;
        logic [16:0] val;
    } t_stg1;

    // after the saturation products
    typedef struct packed {
        t_sector     sector;
        logic        sat_zero;
        logic [16:0] val;
        logic [16:0] one_m_s;
        logic [16:0] s_f;
        logic [16:0] s_fc;
    } t_stg2;

    // after the brightness products
    typedef struct packed {
        t_sector     sector;
        logic        sat_zero;
        logic [16:0] val;
        logic [16:0] p;
        logic [16:0] q;
        logic [16:0] t;
    } t_stg3;

    // x/65535 mapped to 1.0 = 2^16, rounded half up
    function automatic logic [16:0] unit_to_fx(input logic [15:0] x);
        return {1'b0, x} + 17'(x[15]);
    endfunction

    // rounded fixed-point product, operands at most 1.0
    function automatic logic [16:0] fx_mul(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] prod;
        prod = 34'(a) * 34'(b) + 34'(FX_HALF);
        return prod[32:16];
    endfunction

    // value times 255, rounded half up, clamped to a byte
    function automatic logic [7:0] fx_to_byte(input logic [16:0] x);
        logic [24:0] m;
        logic [8:0]  c;
        m = {x, 8'b0} - 25'(x) + 25'(FX_HALF);
        c = m[24:16];
        return (c > 9'd255) ? 8'hFF : c[7:0];
    endfunction

endpackage

// ===== hw/rtl/hsb_to_rgb_converter_unit.sv =====
// top level of the hsb to rgb converter pipeline
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  ------------------------------
// pixel in  input      i_valid / o_ready      i_pix: hue, saturation, brightness
// rgb out   output     o_valid / i_ready      o_rgb: red, green, blue
//
// one item per clock sustained while i_ready stays high
// the four register stages are input scaling, saturation products,
// brightness products, byte conversion with channel routing
// each stage holds its item until the next stage frees; bubbles close up
// under a stall, so input is still taken while the result waits
// i_rst_n is synchronous and clears only the stage valid bits
module hsb_to_rgb_converter_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  h2r_pkg::t_hsb i_pix,
    output logic          o_valid,
    input  logic          i_ready,
    output h2r_pkg::t_rgb o_rgb
);

    // link between input scaling and the products
    logic           s1_valid;
    logic           s1_ready;
    h2r_pkg::t_stg1 s1_data;

    // link between the products and the output stage
    logic           s3_valid;
    logic           s3_ready;
    h2r_pkg::t_stg3 s3_data;

    // sector, fraction and 1.0-scaled s and v
    h2r_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_pix),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    // s*f, s*(1-f), then v*(1-s), v*(1-s*f), v*(1-s*(1-f))
    h2r_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    // scale to bytes and route by sector; gray when saturation is zero
    h2r_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_rgb)
    );

endmodule

// ===== hw/rtl/h2r_prep.sv =====
// input stage: hue sector and fraction, saturation and brightness scaling
module h2r_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  h2r_pkg::t_hsb i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output h2r_pkg::t_stg1 o_data
);

    logic           r_valid;
    h2r_pkg::t_stg1 r_data;
    h2r_pkg::t_stg1 n_data;
    logic [18:0]    hue6;

    // hue*6 as shift and add
    assign hue6 = {1'b0, i_data.hue, 2'b0} + {2'b0, i_data.hue, 1'b0};

    always_comb begin
        n_data.sector   = h2r_pkg::t_sector'(hue6[18:16]);
        n_data.frac     = hue6[15:0];
        n_data.sat_zero = (i_data.saturation == 16'd0);
        n_data.sat      = h2r_pkg::unit_to_fx(i_data.saturation);
        n_data.val      = h2r_pkg::unit_to_fx(i_data.brightness);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/h2r_prod.sv =====
// two multiplier stages: saturation products, then brightness products
module h2r_prod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  h2r_pkg::t_stg1 i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output h2r_pkg::t_stg3 o_data
);

    logic           r_valid2;
    logic           r_valid3;
    logic           ready3;
    h2r_pkg::t_stg2 r_data2;
    h2r_pkg::t_stg2 n_data2;
    h2r_pkg::t_stg3 r_data3;
    h2r_pkg::t_stg3 n_data3;
    logic [16:0]    one_m_f;

    assign one_m_f = h2r_pkg::FX_ONE - {1'b0, i_data.frac};

    // s*f and s*(1-f)
    always_comb begin
        n_data2.sector   = i_data.sector;
        n_data2.sat_zero = i_data.sat_zero;
        n_data2.val      = i_data.val;
        n_data2.one_m_s  = h2r_pkg::FX_ONE - i_data.sat;
        n_data2.s_f      = h2r_pkg::fx_mul(i_data.sat, {1'b0, i_data.frac});
        n_data2.s_fc     = h2r_pkg::fx_mul(i_data.sat, one_m_f);
    end

    // p, q, t
    always_comb begin
        n_data3.sector   = r_data2.sector;
        n_data3.sat_zero = r_data2.sat_zero;
        n_data3.val      = r_data2.val;
        n_data3.p        = h2r_pkg::fx_mul(r_data2.val, r_data2.one_m_s);
        n_data3.q        = h2r_pkg::fx_mul(r_data2.val, h2r_pkg::FX_ONE - r_data2.s_f);
        n_data3.t        = h2r_pkg::fx_mul(r_data2.val, h2r_pkg::FX_ONE - r_data2.s_fc);
    end

    assign ready3  = !r_valid3 || i_ready;
    assign o_ready = !r_valid2 || ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid2 <= i_valid;
            end
            if (ready3) begin
                r_valid3 <= r_valid2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data2 <= n_data2;
        end
        if (ready3 && r_valid2) begin
            r_data3 <= n_data3;
        end
    end

    assign o_valid = r_valid3;
    assign o_data  = r_data3;

endmodule

// ===== hw/rtl/h2r_out.sv =====
// output stage: byte conversion and sector channel routing
module h2r_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  h2r_pkg::t_stg3 i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output h2r_pkg::t_rgb  o_data
);

    logic          r_valid;
    h2r_pkg::t_rgb r_data;
    h2r_pkg::t_rgb n_data;
    logic [7:0]    cv;
    logic [7:0]    cp;
    logic [7:0]    cq;
    logic [7:0]    ct;

    assign cv = h2r_pkg::fx_to_byte(i_data.val);
    assign cp = h2r_pkg::fx_to_byte(i_data.p);
    assign cq = h2r_pkg::fx_to_byte(i_data.q);
    assign ct = h2r_pkg::fx_to_byte(i_data.t);

    always_comb begin
        if (i_data.sat_zero) begin
            n_data = '{red: cv, green: cv, blue: cv};
        end else begin
            case (i_data.sector)
                h2r_pkg::SEC_R_TO_Y: n_data = '{red: cv, green: ct, blue: cp};
                h2r_pkg::SEC_Y_TO_G: n_data = '{red: cq, green: cv, blue: cp};
                h2r_pkg::SEC_G_TO_C: n_data = '{red: cp, green: cv, blue: ct};
                h2r_pkg::SEC_C_TO_B: n_data = '{red: cp, green: cq, blue: cv};
                h2r_pkg::SEC_B_TO_M: n_data = '{red: ct, green: cp, blue: cv};
                default:             n_data = '{red: cv, green: cp, blue: cq};
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/h2r_chk.sv =====
// port-level checker of the hsb to rgb converter, bound to the top level
module h2r_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input h2r_pkg::t_hsb i_pix,
    input logic          o_valid,
    input logic          i_ready,
    input h2r_pkg::t_rgb o_rgb
);

    logic [2:0] r_occ;
    logic [2:0] n_occ;

    // items inside the pipeline
    always_comb begin
        n_occ = r_occ + 3'(i_valid && o_ready) - 3'(o_valid && i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 3'd0;
        end else begin
            r_occ <= n_occ;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_occ != 3'd0)
        else $error("output item without an accepted input item");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= 3'd4)
        else $error("more items in flight than pipeline stages");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_rgb))
        else $error("output item changed while stalled");

endmodule

bind hsb_to_rgb_converter_unit h2r_chk u_h2r_chk (.*);

// ===== test/hsb_to_rgb_checker.sv =====
// checker for the hsb to rgb converter: predicts every rgb item and compares it on arrival
`timescale 1ns / 1ps

module hsb_to_rgb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pix_valid,
    input  logic          i_pix_ready,
    input  h2r_pkg::t_hsb i_pix,
    input  logic          i_rgb_valid,
    input  logic          i_rgb_ready,
    input  h2r_pkg::t_rgb i_rgb,
    output int            o_mismatches,
    output int            o_pending
);

    localparam int              F         = h2r_pkg::FRAC_BITS;
    localparam longint unsigned UNIT      = 64'd1 << F;
    localparam longint unsigned HALF_UNIT = UNIT >> 1;

    h2r_pkg::t_rgb rgb_expected[$];
    int            mismatch_count = 0;
    int            rgb_seen       = 0;

    assign o_mismatches = mismatch_count;

    // x/65535 as a fixed-point fraction, rounded half up
    function automatic longint unsigned scale_unit(input logic [15:0] x);
        return (64'(x) * UNIT + 64'd32767) / 64'd65535;
    endfunction

    function automatic longint unsigned round_mul(input longint unsigned a,
                                                  input longint unsigned b);
        return (a * b + HALF_UNIT) >> F;
    endfunction

    function automatic logic [7:0] to_byte(input longint unsigned x);
        longint unsigned c;
        c = (x * 64'd255 + HALF_UNIT) >> F;
        return (c > 64'd255) ? 8'hFF : 8'(c);
    endfunction

    function automatic h2r_pkg::t_rgb predict_rgb(input h2r_pkg::t_hsb px);
        longint unsigned  sat, val, h6, frac16, frac;
        logic [7:0]       cv, cp, cq, ct;
        h2r_pkg::t_sector sector;
        h2r_pkg::t_rgb    rgb;
        sat = scale_unit(px.saturation);
        val = scale_unit(px.brightness);
        if (sat == 0) begin
            // grey: every channel is the brightness
            cv  = to_byte(val);
            rgb = '{red: cv, green: cv, blue: cv};
        end else begin
            h6     = 64'(px.hue) * 64'd6;
            sector = h2r_pkg::t_sector'(3'(h6 >> 16));
            frac16 = h6 & 64'hFFFF;
            frac   = (F >= 16) ? (frac16 << (F - 16)) : (frac16 >> (16 - F));
            cv = to_byte(val);
            cp = to_byte(round_mul(val, UNIT - sat));
            cq = to_byte(round_mul(val, UNIT - round_mul(sat, frac)));
            ct = to_byte(round_mul(val, UNIT - round_mul(sat, UNIT - frac)));
            case (sector)
                h2r_pkg::SEC_R_TO_Y: rgb = '{red: cv, green: ct, blue: cp};
                h2r_pkg::SEC_Y_TO_G: rgb = '{red: cq, green: cv, blue: cp};
                h2r_pkg::SEC_G_TO_C: rgb = '{red: cp, green: cv, blue: ct};
                h2r_pkg::SEC_C_TO_B: rgb = '{red: cp, green: cq, blue: cv};
                h2r_pkg::SEC_B_TO_M: rgb = '{red: ct, green: cp, blue: cv};
                default:             rgb = '{red: cv, green: cp, blue: cq};
            endcase
        end
        return rgb;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] rgb item %0d: %s", $realtime, rgb_seen, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        h2r_pkg::t_rgb want;
        if (i_rst_n) begin
            if (i_pix_valid && i_pix_ready)
                rgb_expected.push_back(predict_rgb(i_pix));
            if (i_rgb_valid && i_rgb_ready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected item %0d,%0d,%0d",
                                              i_rgb.red, i_rgb.green, i_rgb.blue));
                end else begin
                    want = rgb_expected.pop_front();
                    if (i_rgb.red !== want.red)
                        report_mismatch($sformatf("red %0d, expected %0d",
                                                  i_rgb.red, want.red));
                    if (i_rgb.green !== want.green)
                        report_mismatch($sformatf("green %0d, expected %0d",
                                                  i_rgb.green, want.green));
                    if (i_rgb.blue !== want.blue)
                        report_mismatch($sformatf("blue %0d, expected %0d",
                                                  i_rgb.blue, want.blue));
                end
                rgb_seen++;
            end
        end
        o_pending <= rgb_expected.size();
    end

endmodule

// ===== test/tb_hsb_to_rgb_converter_unit.sv =====
// testbench top for the hsb to rgb converter: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module tb_hsb_to_rgb_converter_unit;

    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 16;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    h2r_pkg::t_hsb i_pix;
    logic          o_valid;
    logic          i_ready;
    h2r_pkg::t_rgb o_rgb;
    int            mismatches;
    int            pending;

    always #1 i_clk = ~i_clk;

    hsb_to_rgb_converter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (o_rgb)
    );

    hsb_to_rgb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_ready  (o_ready),
        .i_pix        (i_pix),
        .i_rgb_valid  (o_valid),
        .i_rgb_ready  (i_ready),
        .i_rgb        (o_rgb),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // holds valid and payload until the item is taken; valid is left high
    task automatic send_pixel(input h2r_pkg::t_hsb px);
        i_valid <= 1'b1;
        i_pix   <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // caller has already lowered valid
    task automatic wait_for_drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd32767;
            3:       return 16'd32768;
            4:       return 16'd65534;
            default: return 16'd65535;
        endcase
    endfunction

    function automatic h2r_pkg::t_hsb make_pixel();
        h2r_pkg::t_hsb px;
        px.hue        = 16'($urandom);
        px.saturation = 16'($urandom);
        px.brightness = 16'($urandom);
        case ($urandom_range(0, 9))
            0: px.saturation = 16'd0;
            1: begin
                px.hue        = corner_value();
                px.saturation = corner_value();
                px.brightness = corner_value();
            end
            // a few codes either side of a sector edge
            2: px.hue = 16'($urandom_range(0, 5) * 10923 + $urandom_range(0, 4) - 2);
            default: ;
        endcase
        return px;
    endfunction

    initial begin : stimulus
        h2r_pkg::t_hsb directed[$];
        int            sent;
        int            burst;
        int            gap;
        bit            drained;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_pix   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // grey cases, pure colors, sector edges, extremes of every field
        directed = '{
            '{16'd0,     16'd0,     16'd0},
            '{16'd0,     16'd0,     16'd65535},
            '{16'd12345, 16'd0,     16'd32768},
            '{16'd0,     16'd65535, 16'd65535},
            '{16'd65535, 16'd65535, 16'd65535},
            '{16'd10922, 16'd65535, 16'd65535},
            '{16'd10923, 16'd65535, 16'd65535},
            '{16'd21846, 16'd65535, 16'd65535},
            '{16'd32768, 16'd65535, 16'd65535},
            '{16'd43691, 16'd65535, 16'd65535},
            '{16'd54613, 16'd65535, 16'd65535},
            '{16'd54614, 16'd65535, 16'd65535},
            '{16'd5461,  16'd32768, 16'd40000},
            '{16'd30000, 16'd1,     16'd65535},
            '{16'd40000, 16'd65535, 16'd0},
            '{16'd50000, 16'd65535, 16'd1},
            '{16'd20000, 16'd32767, 16'd65535},
            '{16'd60000, 16'd65534, 16'd65534},
            '{16'hAAAA,  16'h5555,  16'hAAAA},
            '{16'h5555,  16'hAAAA,  16'h5555},
            '{16'hFFFF,  16'd1,     16'd1}
        };
        foreach (directed[k])
            send_pixel(directed[k]);
        i_valid <= 1'b0;
        wait_for_drain();

        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_pixel(make_pixel());
                sent++;
            end
            if (!drained && sent >= RANDOM_ITEMS / 2) begin
                // let the pipeline empty completely once mid-run
                i_valid <= 1'b0;
                wait_for_drain();
                drained = 1'b1;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // receiver: long ready runs, short flickers and stalls
    initial begin : rgb_sink
        int hold;
        hold = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_ready <= 1'b0;
                        hold = $urandom_range(0, 7);
                    end
                    1: begin
                        i_ready <= 1'b1;
                        hold = $urandom_range(20, 60);
                    end
                    default: begin
                        i_ready <= 1'b1;
                        hold = $urandom_range(0, 3);
                    end
                endcase
            end
        end
    end

    initial begin : watchdog
        #1ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/h2r_pkg.sv
hw/rtl/h2r_prep.sv
hw/rtl/h2r_prod.sv
hw/rtl/h2r_out.sv
hw/rtl/hsb_to_rgb_converter_unit.sv
hw/rtl/h2r_chk.sv
test/hsb_to_rgb_checker.sv
test/tb_hsb_to_rgb_converter_unit.sv
